/* design/rwgc_pkg.sv */
// Shared types and constants of the random walk grid carver.
package rwgc_pkg;

  // Grid bounds in cells
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;

  // Field widths
  localparam int COORD_W   = 6;
  localparam int DIM_W     = 7;
  localparam int COUNT_W   = 13;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 13;

  // Grid memory geometry
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Register reset values
  localparam logic [DIM_W-1:0]   RST_WIDTH  = DIM_W'(64);
  localparam logic [DIM_W-1:0]   RST_HEIGHT = DIM_W'(64);
  localparam logic [COORD_W-1:0] RST_START  = COORD_W'(32);
  localparam logic [COUNT_W-1:0] RST_TARGET = COUNT_W'(2048);

  typedef enum logic [1:0] {
    CMD_RESTART = 2'd0,
    CMD_STEP    = 2'd1,
    CMD_READ    = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    DIR_XP = 2'd0,
    DIR_XM = 2'd1,
    DIR_YP = 2'd2,
    DIR_YM = 2'd3
  } dir_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 3'd0,
    CFG_GRID_HEIGHT = 3'd1,
    CFG_START_X     = 3'd2,
    CFG_START_Y     = 3'd3,
    CFG_TARGET      = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIN,
    S_CLEAR
  } state_t;

  // Effective settings handed from the register block to the controller
  typedef struct packed {
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COUNT_W-1:0] target;
  } cfg_t;

  // Linear cell address, row major
  function automatic logic [ADDR_W-1:0] cell_addr(logic [COORD_W-1:0] x,
                                                  logic [COORD_W-1:0] y);
    cell_addr = ADDR_W'(y) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x);
  endfunction

endpackage

/* design/rwgc_ram.sv */
// Generic single write port, single read port RAM with registered read.
module rwgc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/rwgc_cfg.sv */
// Configuration registers and the effective grid size and start position.
module rwgc_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rwgc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rwgc_pkg::CFG_DW-1:0]     cfg_wdata,
  output rwgc_pkg::cfg_t                  cfg
);

  logic [rwgc_pkg::DIM_W-1:0]   width_r;
  logic [rwgc_pkg::DIM_W-1:0]   height_r;
  logic [rwgc_pkg::COORD_W-1:0] start_x_r;
  logic [rwgc_pkg::COORD_W-1:0] start_y_r;
  logic [rwgc_pkg::COUNT_W-1:0] target_r;

  logic [rwgc_pkg::DIM_W-1:0]   eff_w;
  logic [rwgc_pkg::DIM_W-1:0]   eff_h;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= rwgc_pkg::RST_WIDTH;
      height_r  <= rwgc_pkg::RST_HEIGHT;
      start_x_r <= rwgc_pkg::RST_START;
      start_y_r <= rwgc_pkg::RST_START;
      target_r  <= rwgc_pkg::RST_TARGET;
    end else if (cfg_we) begin
      case (rwgc_pkg::cfg_idx_t'(cfg_index))
        rwgc_pkg::CFG_GRID_WIDTH:  width_r   <= cfg_wdata[rwgc_pkg::DIM_W-1:0];
        rwgc_pkg::CFG_GRID_HEIGHT: height_r  <= cfg_wdata[rwgc_pkg::DIM_W-1:0];
        rwgc_pkg::CFG_START_X:     start_x_r <= cfg_wdata[rwgc_pkg::COORD_W-1:0];
        rwgc_pkg::CFG_START_Y:     start_y_r <= cfg_wdata[rwgc_pkg::COORD_W-1:0];
        rwgc_pkg::CFG_TARGET:      target_r  <= cfg_wdata[rwgc_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero acts as one, oversize clamps to the grid bound
  always_comb begin
    if (width_r == '0) begin
      eff_w = rwgc_pkg::DIM_W'(1);
    end else if (width_r > rwgc_pkg::DIM_W'(rwgc_pkg::MAX_WIDTH)) begin
      eff_w = rwgc_pkg::DIM_W'(rwgc_pkg::MAX_WIDTH);
    end else begin
      eff_w = width_r;
    end
    if (height_r == '0) begin
      eff_h = rwgc_pkg::DIM_W'(1);
    end else if (height_r > rwgc_pkg::DIM_W'(rwgc_pkg::MAX_HEIGHT)) begin
      eff_h = rwgc_pkg::DIM_W'(rwgc_pkg::MAX_HEIGHT);
    end else begin
      eff_h = height_r;
    end
  end

  // Start saturates to the last column or row in use
  always_comb begin
    cfg.width   = eff_w;
    cfg.height  = eff_h;
    cfg.target  = target_r;
    cfg.start_x = ({1'b0, start_x_r} < eff_w) ? start_x_r
                                               : rwgc_pkg::COORD_W'(eff_w - 1'b1);
    cfg.start_y = ({1'b0, start_y_r} < eff_h) ? start_y_r
                                               : rwgc_pkg::COORD_W'(eff_h - 1'b1);
  end

endmodule

/* design/random_walk_grid_carver.sv */
// Top level of the random walk grid carver: controller, walker state and grid memory.
//
// Usage:
//   Requests enter on the in_ stream (cmd in in_tuser), results leave on the out_
//   stream, one result per request. Settings are written through the cfg_ port
//   while the block is idle.
//   Step, read and no-op requests: the accept cycle issues the grid memory read,
//   then S_FIN forms the result and writes a carved cell back once the output
//   register is free. The single memory port pair and this read-then-write
//   sequence mean a new request is taken only after the last one has finished.
//   A restart request sweeps all 4096 grid cells back to wall, one per cycle,
//   before S_FIN forms its result.
//   After reset the same full-grid sweep runs with in_tready low; registers
//   return to their defaults and the walker sits at (0,0) with a zero count.
//   A result waits in the output register while out_tready is low; the
//   following request is then held in its finishing cycle, and no further
//   request is taken until that result has moved into the output register.
module random_walk_grid_carver (
  input  logic        clk,
  input  logic        rst_n,
  // Request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // direction[1:0], read_x[7:2], read_y[13:8], zero pad
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // pos_x[5:0], pos_y[11:6], moved[12], carved[13],
                                  // carved_count[26:14], done_res[27], cell_value[28]
  // Settings
  input  logic                           cfg_we,
  input  logic [rwgc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rwgc_pkg::CFG_DW-1:0]    cfg_wdata
);

  localparam int CW = rwgc_pkg::COORD_W;
  localparam int DW = rwgc_pkg::DIM_W;
  localparam int NW = rwgc_pkg::COUNT_W;
  localparam int AW = rwgc_pkg::ADDR_W;

  rwgc_pkg::cfg_t   cfg;
  rwgc_pkg::state_t state_r, state_nxt;

  // Walker state
  logic [CW-1:0] walker_x_r, walker_x_nxt;
  logic [CW-1:0] walker_y_r, walker_y_nxt;
  logic [NW-1:0] count_r, count_nxt;

  // Request held between accept and finish
  rwgc_pkg::cmd_t cmd_r;
  logic [CW-1:0]  tx_r;
  logic [CW-1:0]  ty_r;
  logic           ok_r;
  logic [AW-1:0]  addr_r;
  logic           pend_r, pend_nxt;

  // Clearing sweep
  logic [AW-1:0]  clr_cnt_r, clr_cnt_nxt;

  // Output register
  logic           out_valid_r, out_valid_nxt;
  logic [31:0]    out_data_r;
  logic           out_load;

  // Request decode
  rwgc_pkg::cmd_t in_cmd;
  rwgc_pkg::dir_t in_dir;
  logic [CW-1:0]  in_rx;
  logic [CW-1:0]  in_ry;
  logic           accept;
  logic [DW-1:0]  nx;
  logic [DW-1:0]  ny;
  logic           step_ok;
  logic           read_in;
  logic [CW-1:0]  acc_tx;
  logic [CW-1:0]  acc_ty;
  logic           acc_ok;
  logic [AW-1:0]  acc_addr;

  // Memory ports
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic           ram_wdata;
  logic           ram_rdata;

  // Result fields
  logic           res_moved;
  logic           res_carved;
  logic           res_cell;
  logic           out_free;

  rwgc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rwgc_ram #(
    .WIDTH (1),
    .DEPTH (rwgc_pkg::DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (acc_addr),
    .rdata (ram_rdata)
  );

  assign in_cmd   = rwgc_pkg::cmd_t'(in_tuser);
  assign in_dir   = rwgc_pkg::dir_t'(in_tdata[1:0]);
  assign in_rx    = in_tdata[7:2];
  assign in_ry    = in_tdata[13:8];
  assign in_tready = (state_r == rwgc_pkg::S_IDLE);
  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // Candidate position; stepping below zero wraps high and fails the bound test
  always_comb begin
    nx = {1'b0, walker_x_r};
    ny = {1'b0, walker_y_r};
    case (in_dir)
      rwgc_pkg::DIR_XP: nx = {1'b0, walker_x_r} + 1'b1;
      rwgc_pkg::DIR_XM: nx = {1'b0, walker_x_r} - 1'b1;
      rwgc_pkg::DIR_YP: ny = {1'b0, walker_y_r} + 1'b1;
      rwgc_pkg::DIR_YM: ny = {1'b0, walker_y_r} - 1'b1;
      default: ;
    endcase
  end

  assign step_ok = (count_r < cfg.target) && (nx < cfg.width) && (ny < cfg.height);
  assign read_in = ({1'b0, in_rx} < cfg.width) && ({1'b0, in_ry} < cfg.height);

  // What the request carries to its finishing cycle
  always_comb begin
    acc_tx   = walker_x_r;
    acc_ty   = walker_y_r;
    acc_ok   = 1'b0;
    acc_addr = rwgc_pkg::cell_addr(in_rx, in_ry);
    case (in_cmd)
      rwgc_pkg::CMD_RESTART: begin
        acc_tx = cfg.start_x;
        acc_ty = cfg.start_y;
      end
      rwgc_pkg::CMD_STEP: begin
        acc_tx   = nx[CW-1:0];
        acc_ty   = ny[CW-1:0];
        acc_ok   = step_ok;
        acc_addr = rwgc_pkg::cell_addr(nx[CW-1:0], ny[CW-1:0]);
      end
      rwgc_pkg::CMD_READ: acc_ok = read_in;
      default: ;
    endcase
  end

  // Controller: next state, walker update, memory writes
  always_comb begin
    state_nxt     = state_r;
    walker_x_nxt  = walker_x_r;
    walker_y_nxt  = walker_y_r;
    count_nxt     = count_r;
    pend_nxt      = pend_r;
    clr_cnt_nxt   = clr_cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_load      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = addr_r;
    ram_wdata     = 1'b0;
    res_moved     = 1'b0;
    res_carved    = 1'b0;
    res_cell      = 1'b0;
    case (state_r)
      rwgc_pkg::S_IDLE: begin
        if (accept) begin
          clr_cnt_nxt = '0;
          pend_nxt    = 1'b1;
          state_nxt   = (in_cmd == rwgc_pkg::CMD_RESTART) ? rwgc_pkg::S_CLEAR
                                                          : rwgc_pkg::S_FIN;
        end
      end
      rwgc_pkg::S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(rwgc_pkg::DEPTH - 1)) begin
          state_nxt = pend_r ? rwgc_pkg::S_FIN : rwgc_pkg::S_IDLE;
        end
      end
      rwgc_pkg::S_FIN: begin
        case (cmd_r)
          rwgc_pkg::CMD_RESTART: begin
            walker_x_nxt = tx_r;
            walker_y_nxt = ty_r;
            count_nxt    = '0;
          end
          rwgc_pkg::CMD_STEP: begin
            if (ok_r) begin
              res_moved    = 1'b1;
              res_carved   = ram_rdata;
              walker_x_nxt = tx_r;
              walker_y_nxt = ty_r;
              if (ram_rdata && (count_r < rwgc_pkg::COUNT_MAX)) begin
                count_nxt = count_r + 1'b1;
              end
            end
          end
          rwgc_pkg::CMD_READ: res_cell = ok_r ? ram_rdata : 1'b1;
          default: ;
        endcase
        if (out_free) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          pend_nxt      = 1'b0;
          ram_we        = res_carved;
          state_nxt     = rwgc_pkg::S_IDLE;
        end else begin
          walker_x_nxt = walker_x_r;
          walker_y_nxt = walker_y_r;
          count_nxt    = count_r;
        end
      end
      default: state_nxt = rwgc_pkg::S_IDLE;
    endcase
  end

  // Control registers; reset starts a clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rwgc_pkg::S_CLEAR;
      walker_x_r  <= '0;
      walker_y_r  <= '0;
      count_r     <= '0;
      pend_r      <= 1'b0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      walker_x_r  <= walker_x_nxt;
      walker_y_r  <= walker_y_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Request payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_cmd;
      tx_r   <= acc_tx;
      ty_r   <= acc_ty;
      ok_r   <= acc_ok;
      addr_r <= acc_addr;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {3'b000, res_cell, (count_nxt >= cfg.target), count_nxt,
                     res_carved, res_moved, walker_y_nxt, walker_x_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Grid writes only come from the sweep or a finishing step
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == rwgc_pkg::S_CLEAR || state_r == rwgc_pkg::S_FIN))
    else $error("grid write outside sweep or finish");

  // A carve always comes with a move
  a_carve_moves: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[13] && !out_tdata[12]))
    else $error("carved without moving");

  // The count holds while no request is in flight
  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rwgc_pkg::S_IDLE |=> $stable(count_r))
    else $error("count changed while idle");

  // A finished request leaves through the output register
  a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rwgc_pkg::S_FIN && state_nxt == rwgc_pkg::S_IDLE) |=> out_tvalid)
    else $error("finished request produced no result");

endmodule

/* dv/random_walk_grid_carver_tb.sv */
// Self-checking testbench for the random walk grid carver: request driver, result monitor, walk model.
module random_walk_grid_carver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rwgc_pkg::*;

  // Result fields, lowest bits last
  typedef struct packed {
    logic               cell_val;
    logic               done;
    logic [COUNT_W-1:0] count;
    logic               carved;
    logic               moved;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } walk_res_t;

  typedef struct {
    cmd_t               cmd;
    dir_t               dir;
    logic [COORD_W-1:0] rx;
    logic [COORD_W-1:0] ry;
    bit                 hold;   // wait for every outstanding result before sending
  } walk_req_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [15:0]          in_tdata   = '0;   // direction[1:0], read_x[7:2], read_y[13:8]
  logic [1:0]           in_tuser   = '0;   // cmd[1:0]
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [31:0]          out_tdata;         // pos_x, pos_y, moved, carved, count, done, cell
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_DW-1:0]    cfg_wdata  = '0;

  random_walk_grid_carver u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Walk model state and its copy of the settings
  logic               grid_wall [DEPTH] = '{default: 1'b1};
  logic [COORD_W-1:0] walk_x  = '0;
  logic [COORD_W-1:0] walk_y  = '0;
  logic [COUNT_W-1:0] carve_n = '0;
  logic [DIM_W-1:0]   cfg_w   = RST_WIDTH;
  logic [DIM_W-1:0]   cfg_h   = RST_HEIGHT;
  logic [COORD_W-1:0] cfg_sx  = RST_START;
  logic [COORD_W-1:0] cfg_sy  = RST_START;
  logic [COUNT_W-1:0] cfg_tgt = RST_TARGET;

  walk_req_t req_q[$];
  walk_res_t walk_res_q[$];

  int  send_idle_pct = 6;
  int  recv_idle_pct = 85;
  logic in_fire_q    = 1'b0;

  int queued_n, results_n, mismatch_n, settings_n;
  int n_restart, n_carve, n_refused, n_ignored;

  // Size in use: zero acts as one, oversize clips to the maximum
  function automatic int eff_dim(int v, int maxv);
    if (v == 0) return 1;
    return (v > maxv) ? maxv : v;
  endfunction

  // Advance the walk model by one request and form its result
  function automatic walk_res_t carve_predict(cmd_t cmd, dir_t dir,
                                              logic [COORD_W-1:0] rx,
                                              logic [COORD_W-1:0] ry);
    walk_res_t r;
    int w, h, nx, ny;
    r = '0;
    w = eff_dim(cfg_w, MAX_WIDTH);
    h = eff_dim(cfg_h, MAX_HEIGHT);
    case (cmd)
      CMD_RESTART: begin
        foreach (grid_wall[i]) grid_wall[i] = 1'b1;
        walk_x  = (int'(cfg_sx) < w) ? cfg_sx : COORD_W'(w - 1);
        walk_y  = (int'(cfg_sy) < h) ? cfg_sy : COORD_W'(h - 1);
        carve_n = '0;
        n_restart++;
      end
      CMD_STEP: begin
        if (carve_n < cfg_tgt) begin
          nx = walk_x;
          ny = walk_y;
          case (dir)
            DIR_XP:  nx = nx + 1;
            DIR_XM:  nx = nx - 1;
            DIR_YP:  ny = ny + 1;
            default: ny = ny - 1;
          endcase
          // stepping off the low edge gives -1 and fails like the high edge
          if (nx >= 0 && nx < w && ny >= 0 && ny < h) begin
            walk_x  = COORD_W'(nx);
            walk_y  = COORD_W'(ny);
            r.moved = 1'b1;
            if (grid_wall[ny * MAX_WIDTH + nx]) begin
              grid_wall[ny * MAX_WIDTH + nx] = 1'b0;
              r.carved = 1'b1;
              n_carve++;
              if (carve_n != COUNT_MAX) carve_n = carve_n + 1'b1;
            end
          end else begin
            n_refused++;
          end
        end else begin
          n_ignored++;
        end
      end
      CMD_READ: begin
        if (int'(rx) < w && int'(ry) < h) r.cell_val = grid_wall[int'(ry) * MAX_WIDTH + int'(rx)];
        else r.cell_val = 1'b1;
      end
      default: ;
    endcase
    r.x     = walk_x;
    r.y     = walk_y;
    r.count = carve_n;
    r.done  = (carve_n >= cfg_tgt);
    return r;
  endfunction

  function automatic void queue_req(cmd_t c, dir_t d, int rx, int ry, bit hold = 1'b0);
    walk_req_t q;
    q.cmd  = c;
    q.dir  = d;
    q.rx   = COORD_W'(rx);
    q.ry   = COORD_W'(ry);
    q.hold = hold;
    req_q.push_back(q);
    queued_n++;
  endfunction

  // One register write, mirrored into the model copy
  task automatic write_setting(cfg_idx_t idx, int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DW'(val);
    case (idx)
      CFG_GRID_WIDTH:  cfg_w   = DIM_W'(val);
      CFG_GRID_HEIGHT: cfg_h   = DIM_W'(val);
      CFG_START_X:     cfg_sx  = COORD_W'(val);
      CFG_START_Y:     cfg_sy  = COORD_W'(val);
      default:         cfg_tgt = COUNT_W'(val);
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_grid(int w, int h, int sx, int sy, int tgt);
    write_setting(CFG_GRID_WIDTH, w);
    write_setting(CFG_GRID_HEIGHT, h);
    write_setting(CFG_START_X, sx);
    write_setting(CFG_START_Y, sy);
    write_setting(CFG_TARGET, tgt);
    settings_n++;
  endtask

  // Wait until every queued request has its result back, then let the bench idle
  task automatic settle();
    while (results_n != queued_n) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Request driver
  always @(negedge clk) begin
    walk_req_t req;
    logic      send;
    send = 1'b0;
    if (!in_tvalid || in_fire_q) begin
      if (rst_n && req_q.size() > 0 && $urandom_range(99) >= send_idle_pct &&
          !(req_q[0].hold && walk_res_q.size() != 0)) begin
        req = req_q.pop_front();
        send = 1'b1;
        in_tdata <= {2'b00, req.ry, req.rx, req.dir};
        in_tuser <= req.cmd;
      end
      in_tvalid <= send;
    end
  end

  // Result receiver backpressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin
    walk_res_t got, want;
    in_fire_q <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready)
      walk_res_q.push_back(carve_predict(cmd_t'(in_tuser), dir_t'(in_tdata[1:0]),
                                         in_tdata[7:2], in_tdata[13:8]));
    if (rst_n && out_tvalid && out_tready) begin
      got = walk_res_t'(out_tdata[28:0]);
      if (walk_res_q.size() == 0) begin
        mismatch_n++;
        if (mismatch_n <= 10) $display("%0t: result with no request outstanding", $realtime);
      end else begin
        want = walk_res_q.pop_front();
        results_n++;
        if (got !== want) begin
          mismatch_n++;
          if (mismatch_n <= 10) begin
            $display("%0t: mismatch on result %0d", $realtime, results_n);
            $display("  got  pos=(%0d,%0d) moved=%b carved=%b count=%0d done=%b cell=%b",
                     got.x, got.y, got.moved, got.carved, got.count, got.done, got.cell_val);
            $display("  want pos=(%0d,%0d) moved=%b carved=%b count=%0d done=%b cell=%b",
                     want.x, want.y, want.moved, want.carved, want.count, want.done,
                     want.cell_val);
          end
        end
      end
    end
  end

  // Stimulus sequence
  initial begin
    int w, h, ew, eh, cells, tgt, sx, sy, r, rx, ry;
    cmd_t c;

    // Walk on the reset grid before any restart: walker at origin, all wall
    queue_req(CMD_STEP, DIR_XM, 0, 0);
    queue_req(CMD_STEP, DIR_YM, 63, 63);
    queue_req(CMD_STEP, DIR_XP, 0, 0);
    queue_req(CMD_STEP, DIR_YP, 0, 0);
    queue_req(CMD_STEP, DIR_XM, 0, 0);
    queue_req(CMD_STEP, DIR_YM, 0, 0);
    queue_req(CMD_READ, DIR_XP, 1, 0);
    queue_req(CMD_READ, DIR_YM, 63, 63);
    queue_req(CMD_NOP, DIR_YM, 63, 63);
    // Restart refills walls; the start cell stays wall until walked back onto
    queue_req(CMD_RESTART, DIR_XP, 0, 0);
    queue_req(CMD_READ, DIR_XP, 1, 0);
    queue_req(CMD_STEP, DIR_XP, 0, 0);
    queue_req(CMD_STEP, DIR_XM, 0, 0);
    queue_req(CMD_STEP, DIR_XM, 0, 0);
    queue_req(CMD_STEP, DIR_XP, 0, 0);
    queue_req(CMD_READ, DIR_XP, 32, 32);

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    settle();

    // Zero size acts as 1x1, start saturates to the origin, every move refused
    apply_grid(0, 0, 5, 9, 1);
    queue_req(CMD_RESTART, DIR_XP, 0, 0);
    queue_req(CMD_STEP, DIR_XP, 0, 0);
    queue_req(CMD_STEP, DIR_YP, 0, 0);
    queue_req(CMD_READ, DIR_XP, 0, 0);
    queue_req(CMD_READ, DIR_XP, 63, 0);
    settle();

    // Zero target: done right at restart, steps ignored
    apply_grid(2, 1, 0, 0, 0);
    queue_req(CMD_RESTART, DIR_XP, 0, 0);
    queue_req(CMD_STEP, DIR_XP, 0, 0);
    settle();

    // Oversize grid clips to full size, start in the far corner, top target
    apply_grid(127, 100, 63, 63, 8191);
    queue_req(CMD_RESTART, DIR_XP, 0, 0);
    queue_req(CMD_STEP, DIR_XP, 0, 0);
    queue_req(CMD_STEP, DIR_YP, 0, 0);
    queue_req(CMD_STEP, DIR_YM, 0, 0);
    settle();

    // Random walks under varied grids; most phases open with a restart
    for (int p = 0; p < 16; p++) begin
      if (p == 6) begin
        send_idle_pct = 85;
        recv_idle_pct = 6;
      end else if (p == 11) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      r = $urandom_range(9);
      w = (r == 0) ? 0 : (r == 1) ? 64 : (r == 2) ? $urandom_range(65, 127)
                                                  : $urandom_range(1, 10);
      r = $urandom_range(9);
      h = (r == 0) ? 0 : (r == 1) ? 64 : (r == 2) ? $urandom_range(65, 127)
                                                  : $urandom_range(1, 10);
      ew = eff_dim(w, MAX_WIDTH);
      eh = eff_dim(h, MAX_HEIGHT);
      cells = ew * eh;
      r = $urandom_range(9);
      tgt = (r == 0) ? 0 : (r == 1) ? $urandom_range(cells + 1, 8191) :
            (r == 2) ? cells : $urandom_range(1, (cells + 1) / 2);
      r = $urandom_range(9);
      sx = (r == 0) ? 0 : (r == 1) ? 63 : (r == 2) ? $urandom_range(63)
                                                   : $urandom_range(ew - 1);
      r = $urandom_range(9);
      sy = (r == 0) ? 0 : (r == 1) ? 63 : (r == 2) ? $urandom_range(63)
                                                   : $urandom_range(eh - 1);
      apply_grid(w, h, sx, sy, tgt);

      if ($urandom_range(99) < 85) queue_req(CMD_RESTART, DIR_XP, 0, 0);
      for (int i = 0; i < 100; i++) begin
        r  = $urandom_range(99);
        rx = $urandom_range(63);
        ry = $urandom_range(63);
        if (r < 72) begin
          c = CMD_STEP;
        end else if (r < 86) begin
          c = CMD_READ;
          if ($urandom_range(9) < 7) begin
            rx = $urandom_range(ew - 1);
            ry = $urandom_range(eh - 1);
          end
        end else if (r < 92) begin
          c = CMD_NOP;
        end else if (r < 94) begin
          c = CMD_RESTART;
        end else begin
          c = cmd_t'($urandom_range(3));
        end
        queue_req(c, dir_t'($urandom_range(3)), rx, ry, $urandom_range(99) < 2);
      end
      settle();
    end

    $display("Ran %0d requests over %0d grid settings: %0d restarts, %0d cells carved, %0d refused",
             queued_n, settings_n, n_restart, n_carve, n_refused);
    $display("%0d steps ignored after reaching target; %0d results compared, %0d mismatches",
             n_ignored, results_n, mismatch_n);
    if (mismatch_n == 0 && walk_res_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #30_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* random_walk_grid_carver.f */
design/rwgc_pkg.sv
design/rwgc_ram.sv
design/rwgc_cfg.sv
design/random_walk_grid_carver.sv
dv/random_walk_grid_carver_tb.sv
